/* design/sgi_pkg.sv */
`default_nettype none

package sgi_pkg;

  localparam int COORD_WIDTH = 16;
  // coordinate difference, one bit wider than a coordinate
  localparam int DW = COORD_WIDTH + 1;
  // product of two differences
  localparam int PW = 2 * DW;
  // cross-product denominator and numerators, signed
  localparam int NW = PW + 1;
  // magnitude of denominator and numerator after sign normalization
  localparam int MW = 2 * COORD_WIDTH + 2;
  // quotient bits: the scaled offset never exceeds the axis span
  localparam int QW = COORD_WIDTH;
  // scaled numerator na * |delta|
  localparam int NPW = MW + QW;
  // split of na for the two partial products
  localparam int LO_W = COORD_WIDTH + 2;
  localparam int HI_W = MW - LO_W;
  // cycles from the accepting edge to the edge that takes the result
  localparam int LATENCY = QW + 8;

  localparam int AX_X = 0;
  localparam int AX_Y = 1;
  localparam int AX_Z = 2;

  typedef struct packed {
    logic                          use_xz;
    logic signed [COORD_WIDTH-1:0] a_begin_x;
    logic signed [COORD_WIDTH-1:0] a_begin_y;
    logic signed [COORD_WIDTH-1:0] a_begin_z;
    logic signed [COORD_WIDTH-1:0] a_end_x;
    logic signed [COORD_WIDTH-1:0] a_end_y;
    logic signed [COORD_WIDTH-1:0] a_end_z;
    logic signed [COORD_WIDTH-1:0] b_begin_x;
    logic signed [COORD_WIDTH-1:0] b_begin_v;
    logic signed [COORD_WIDTH-1:0] b_end_x;
    logic signed [COORD_WIDTH-1:0] b_end_v;
  } sgi_in_t;

  typedef struct packed {
    logic                          hit;
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [COORD_WIDTH-1:0] pos_z;
  } sgi_out_t;

  // what travels alongside the arithmetic to the last stage
  typedef struct packed {
    logic                               hit;
    logic [2:0][COORD_WIDTH-1:0]        bgn;
    logic [2:0]                         neg;
  } sgi_side_t;

  typedef struct packed {
    sgi_side_t             side;
    logic [MW-1:0]         dn;
    logic [MW-1:0]         na;
    logic [2:0][QW-1:0]    md;
  } sgi_geo_t;

  function automatic logic signed [DW-1:0] sx(input logic signed [COORD_WIDTH-1:0] a);
    return {a[COORD_WIDTH-1], a};
  endfunction

endpackage

`default_nettype wire

/* design/sgi_cross.sv */
`default_nettype none

module sgi_cross (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_vld,
  input  sgi_pkg::sgi_in_t     in_item,
  output logic                 geo_vld,
  output sgi_pkg::sgi_geo_t    geo
);
  import sgi_pkg::*;

  // stage 1: differences
  logic                          v1_r;
  logic signed [DW-1:0]          dax_r, day_r, daz_r, dav_r, dbx_r, dbv_r, ox_r, ov_r;
  logic [2:0][COORD_WIDTH-1:0]   bgn1_r;

  // stage 2: products, delta magnitudes
  logic                          v2_r;
  logic signed [PW-1:0]          pd1_r, pd2_r, pa1_r, pa2_r, pb1_r, pb2_r;
  logic [2:0][COORD_WIDTH-1:0]   bgn2_r;
  logic [2:0]                    neg2_r;
  logic [2:0][QW-1:0]            md2_r;

  // stage 3: cross products
  logic                          v3_r;
  logic signed [NW-1:0]          dn3_r, na3_r, nb3_r;
  logic [2:0][COORD_WIDTH-1:0]   bgn3_r;
  logic [2:0]                    neg3_r;
  logic [2:0][QW-1:0]            md3_r;

  // stage 4: positive denominator
  logic                          v4_r;
  logic                          dz4_r;
  logic signed [NW-1:0]          dn4_r, na4_r, nb4_r;
  logic [2:0][COORD_WIDTH-1:0]   bgn4_r;
  logic [2:0]                    neg4_r;
  logic [2:0][QW-1:0]            md4_r;

  // stage 5
  logic                          v5_r;
  sgi_geo_t                      geo_r;

  logic signed [PW-1:0]          pd1, pd2, pa1, pa2, pb1, pb2;
  logic signed [DW-1:0]          dsel [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    dax_r <= sx(in_item.a_end_x) - sx(in_item.a_begin_x);
    day_r <= sx(in_item.a_end_y) - sx(in_item.a_begin_y);
    daz_r <= sx(in_item.a_end_z) - sx(in_item.a_begin_z);
    dav_r <= in_item.use_xz ? sx(in_item.a_end_z) - sx(in_item.a_begin_z)
                            : sx(in_item.a_end_y) - sx(in_item.a_begin_y);
    dbx_r <= sx(in_item.b_end_x) - sx(in_item.b_begin_x);
    dbv_r <= sx(in_item.b_end_v) - sx(in_item.b_begin_v);
    ox_r  <= sx(in_item.a_begin_x) - sx(in_item.b_begin_x);
    ov_r  <= (in_item.use_xz ? sx(in_item.a_begin_z) : sx(in_item.a_begin_y))
             - sx(in_item.b_begin_v);
    bgn1_r[AX_X] <= in_item.a_begin_x;
    bgn1_r[AX_Y] <= in_item.a_begin_y;
    bgn1_r[AX_Z] <= in_item.a_begin_z;
  end

  always_comb begin
    pd1 = dbv_r * dax_r;
    pd2 = dbx_r * dav_r;
    pa1 = dbx_r * ov_r;
    pa2 = dbv_r * ox_r;
    pb1 = dax_r * ov_r;
    pb2 = dav_r * ox_r;
    dsel[AX_X] = dax_r;
    dsel[AX_Y] = day_r;
    dsel[AX_Z] = daz_r;
  end

  always_ff @(posedge clk) begin
    pd1_r  <= pd1;
    pd2_r  <= pd2;
    pa1_r  <= pa1;
    pa2_r  <= pa2;
    pb1_r  <= pb1;
    pb2_r  <= pb2;
    bgn2_r <= bgn1_r;
    for (int a = 0; a < 3; a++) begin
      neg2_r[a] <= dsel[a][DW-1];
      md2_r[a]  <= dsel[a][DW-1] ? QW'(-dsel[a]) : QW'(dsel[a]);
    end
  end

  always_ff @(posedge clk) begin
    dn3_r  <= {pd1_r[PW-1], pd1_r} - {pd2_r[PW-1], pd2_r};
    na3_r  <= {pa1_r[PW-1], pa1_r} - {pa2_r[PW-1], pa2_r};
    nb3_r  <= {pb1_r[PW-1], pb1_r} - {pb2_r[PW-1], pb2_r};
    bgn3_r <= bgn2_r;
    neg3_r <= neg2_r;
    md3_r  <= md2_r;
  end

  // flip all three so the denominator is positive
  always_ff @(posedge clk) begin
    dz4_r  <= (dn3_r == '0);
    dn4_r  <= dn3_r[NW-1] ? -dn3_r : dn3_r;
    na4_r  <= dn3_r[NW-1] ? -na3_r : na3_r;
    nb4_r  <= dn3_r[NW-1] ? -nb3_r : nb3_r;
    bgn4_r <= bgn3_r;
    neg4_r <= neg3_r;
    md4_r  <= md3_r;
  end

  // both parameters in [0,1]
  always_ff @(posedge clk) begin
    geo_r.side.hit <= !dz4_r && !na4_r[NW-1] && !nb4_r[NW-1]
                      && (na4_r <= dn4_r) && (nb4_r <= dn4_r);
    geo_r.side.bgn <= bgn4_r;
    geo_r.side.neg <= neg4_r;
    geo_r.dn       <= dn4_r[MW-1:0];
    geo_r.na       <= na4_r[MW-1:0];
    geo_r.md       <= md4_r;
  end

  assign geo_vld = v5_r;
  assign geo     = geo_r;

endmodule

`default_nettype wire

/* design/sgi_scale.sv */
`default_nettype none

module sgi_scale (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              geo_vld,
  input  sgi_pkg::sgi_geo_t                      geo,
  output logic                                   num_vld,
  output logic [sgi_pkg::MW-1:0]                 num_dn,
  output logic [2:0][sgi_pkg::NPW-1:0]           num,
  output sgi_pkg::sgi_side_t                     num_side
);
  import sgi_pkg::*;

  logic                              va_r, vb_r;
  logic [2:0][LO_W+QW-1:0]           plo_r;
  logic [2:0][HI_W+QW-1:0]           phi_r;
  logic [MW-1:0]                     dna_r, dnb_r;
  sgi_side_t                         sidea_r, sideb_r;
  logic [2:0][NPW-1:0]               num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= geo_vld;
      vb_r <= va_r;
    end
  end

  // partial products of na * |delta|
  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      plo_r[a] <= geo.na[LO_W-1:0] * geo.md[a];
      phi_r[a] <= geo.na[MW-1:LO_W] * geo.md[a];
    end
    dna_r   <= geo.dn;
    sidea_r <= geo.side;
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      num_r[a] <= {phi_r[a], {LO_W{1'b0}}} + NPW'(plo_r[a]);
    end
    dnb_r   <= dna_r;
    sideb_r <= sidea_r;
  end

  assign num_vld  = vb_r;
  assign num_dn   = dnb_r;
  assign num      = num_r;
  assign num_side = sideb_r;

endmodule

`default_nettype wire

/* design/sgi_div.sv */
`default_nettype none

module sgi_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      num_vld,
  input  wire logic [sgi_pkg::MW-1:0]    num_dn,
  input  wire logic [2:0][sgi_pkg::NPW-1:0] num,
  input  sgi_pkg::sgi_side_t             num_side,
  output logic                           q_vld,
  output logic [2:0][sgi_pkg::QW-1:0]    q,
  output sgi_pkg::sgi_side_t             q_side
);
  import sgi_pkg::*;

  // one quotient bit per stage, three axes share the divisor
  logic [QW:0]               v_w;
  logic [MW-1:0]             dn_w   [QW+1];
  logic [2:0][MW-1:0]        rem_w  [QW+1];
  logic [2:0][QW-1:0]        qb_w   [QW+1];
  sgi_side_t                 side_w [QW+1];

  assign v_w[0]    = num_vld;
  assign dn_w[0]   = num_dn;
  assign side_w[0] = num_side;

  for (genvar a = 0; a < 3; a++) begin : g_load
    assign rem_w[0][a] = num[a][NPW-1:QW];
    assign qb_w[0][a]  = num[a][QW-1:0];
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic                  v_r;
    logic [MW-1:0]         dn_r;
    logic [2:0][MW-1:0]    rem_r, rem_nxt;
    logic [2:0][QW-1:0]    qb_r, qb_nxt;
    sgi_side_t             side_r;

    always_comb begin
      logic [MW:0] t;
      logic [MW:0] s;
      for (int a = 0; a < 3; a++) begin
        t = {rem_w[k][a], qb_w[k][a][QW-1]};
        s = t - {1'b0, dn_w[k]};
        if (t >= {1'b0, dn_w[k]}) begin
          rem_nxt[a] = s[MW-1:0];
          qb_nxt[a]  = {qb_w[k][a][QW-2:0], 1'b1};
        end else begin
          rem_nxt[a] = t[MW-1:0];
          qb_nxt[a]  = {qb_w[k][a][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else begin
        v_r <= v_w[k];
      end
    end

    always_ff @(posedge clk) begin
      dn_r   <= dn_w[k];
      rem_r  <= rem_nxt;
      qb_r   <= qb_nxt;
      side_r <= side_w[k];
    end

    assign v_w[k+1]    = v_r;
    assign dn_w[k+1]   = dn_r;
    assign rem_w[k+1]  = rem_r;
    assign qb_w[k+1]   = qb_r;
    assign side_w[k+1] = side_r;
  end

  assign q_vld  = v_w[QW];
  assign q      = qb_w[QW];
  assign q_side = side_w[QW];

endmodule

`default_nettype wire

/* design/segment_intersect_2d.sv */
`default_nettype none

// 2-d segment intersection, fully pipelined
// input: drive in_item and raise start; a beat is taken on every edge with
//   start high, busy is never raised, so one pair can enter each cycle
// in_item carries segment A (both ends, x/y/z) and segment B (x and the
//   plane coordinate v); use_xz picks the x/y or the x/z plane
// output: out_valid is high for exactly one cycle per input beat, with
//   out_item holding hit and the point on A (all zero on a miss); the
//   receiver has no way to hold results, and none is needed
// throughput: one beat/cycle
// the pipeline is the restoring divider, one quotient bit per stage,
//   plus five stages of cross-product setup, two for the scaling multiply
//   and the output register
// results leave in the order the beats came in
// reset: synchronous, active low, clears every stage's valid bit so
//   in-flight beats are dropped; no state survives between beats
module segment_intersect_2d (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  sgi_pkg::sgi_in_t   in_item,
  output logic               out_valid,
  output sgi_pkg::sgi_out_t  out_item
);
  import sgi_pkg::*;

  logic                 geo_vld;
  sgi_geo_t             geo;
  logic                 num_vld;
  logic [MW-1:0]        num_dn;
  logic [2:0][NPW-1:0]  num;
  sgi_side_t            num_side;
  logic                 q_vld;
  logic [2:0][QW-1:0]   q;
  sgi_side_t            q_side;

  logic                 out_valid_r;
  sgi_out_t             out_item_r, out_item_nxt;
  logic [2:0][COORD_WIDTH-1:0] pos;

  // pipeline never stalls
  assign busy = 1'b0;

  // deltas, cross products, range check
  sgi_cross u_cross (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (start),
    .in_item (in_item),
    .geo_vld (geo_vld),
    .geo     (geo)
  );

  // na * |delta| per axis
  sgi_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .geo_vld  (geo_vld),
    .geo      (geo),
    .num_vld  (num_vld),
    .num_dn   (num_dn),
    .num      (num),
    .num_side (num_side)
  );

  // truncating divide by the denominator
  sgi_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .num_vld  (num_vld),
    .num_dn   (num_dn),
    .num      (num),
    .num_side (num_side),
    .q_vld    (q_vld),
    .q        (q),
    .q_side   (q_side)
  );

  // quotient is the offset magnitude; apply the delta's sign
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (!q_side.hit) begin
        pos[a] = '0;
      end else if (q_side.neg[a]) begin
        pos[a] = q_side.bgn[a] - q[a];
      end else begin
        pos[a] = q_side.bgn[a] + q[a];
      end
    end
    out_item_nxt.hit   = q_side.hit;
    out_item_nxt.pos_x = pos[AX_X];
    out_item_nxt.pos_y = pos[AX_Y];
    out_item_nxt.pos_z = pos[AX_Z];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= q_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

/* design/sgi_chk.sv */
`default_nettype none

module sgi_chk (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          start,
  input wire logic          busy,
  input sgi_pkg::sgi_in_t   in_item,
  input wire logic          out_valid,
  input sgi_pkg::sgi_out_t  out_item
);
  import sgi_pkg::*;

  // every beat is taken
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  // each result traces back to a beat a fixed latency earlier
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LATENCY))
    else $error("result without matching input beat");

  // a miss carries a zero point
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.hit |->
      out_item.pos_x == '0 && out_item.pos_y == '0 && out_item.pos_z == '0)
    else $error("miss with nonzero point");

  // a hit lies between the x ends of segment A
  a_hit_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.hit |->
      (out_item.pos_x >= $past(in_item.a_begin_x, LATENCY) &&
       out_item.pos_x <= $past(in_item.a_end_x, LATENCY)) ||
      (out_item.pos_x <= $past(in_item.a_begin_x, LATENCY) &&
       out_item.pos_x >= $past(in_item.a_end_x, LATENCY)))
    else $error("hit point outside segment A");

endmodule

bind segment_intersect_2d sgi_chk u_sgi_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);

`default_nettype wire
